// ----- design/psu_pkg.sv -----
// Shared types, constants and helpers for the packed symbol table unpacker.
// No dependencies; every other design file imports this package.
`default_nettype none

package psu_pkg;

  // Fixed field and register widths.
  localparam int WORD_BITS   = 32;
  localparam int SYM_BITS_W  = 3;
  localparam int TOTAL_W     = 24;
  localparam int CODE_W      = 8;
  localparam int IDX_W       = 7;   // widest index, b = 7
  localparam int COUNT_W     = 6;   // holds 0 .. WORD_BITS
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int TBL_SEL_W   = 2;   // which of the four table words
  localparam int CODES_PER_WORD = CFG_DATA_W / CODE_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_BITS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL_TOTAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_A      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_B      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_C      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_D      = 3'd5;

  // Write request into the code table.
  typedef struct packed {
    logic                  en;
    logic [TBL_SEL_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] data;
  } tbl_wr_t;

  // Number of indices that fit in one word for a given index width.
  // Zero bits stands for a single-symbol alphabet: one symbol per word bit.
  function automatic logic [COUNT_W-1:0] per_word(input logic [SYM_BITS_W-1:0] b);
    logic [COUNT_W-1:0] n;
    unique case (b)
      3'd0:    n = 6'd32;
      3'd1:    n = 6'd32;
      3'd2:    n = 6'd16;
      3'd3:    n = 6'd10;
      3'd4:    n = 6'd8;
      3'd5:    n = 6'd6;
      3'd6:    n = 6'd5;
      default: n = 6'd4;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- design/packed_symbol_table_unpack.sv -----
// Top level of the packed symbol table unpacker: stream ports, configuration
// registers and the digit-serial index shifter. Depends on psu_pkg and psu_code_table.
`default_nettype none

// Each 32-bit input word carries up to floor(32 / b) indices of b bits, the
// first in the lowest bits. The block takes k of them, where k is that maximum
// or the number of symbols still owed, whichever is smaller, and sends them
// highest-of-the-k first, each mapped through the code table, one symbol per
// cycle while the output is not stalled. A word is taken only once the
// previous word's symbols have all been moved into the output register. The
// index shift register moves one index of b bits toward its top for each
// symbol sent. Once symbol_total symbols have gone out, further words are
// taken and dropped; writing symbol_total restarts the count. With b = 0 the
// word's bits are ignored and table entry 0 is sent for each slot.
// Configuration writes take effect at once and are meant for idle periods.
module packed_symbol_table_unpack #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  // Input word stream.
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [31:0]                       s_axis_tdata,   // [31:0] packed_word
  // Decoded symbol stream.
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [31:0]                       m_axis_tdata,   // [7:0] symbol_code,
                                                            // [31:8] symbol_number
  output logic                              m_axis_tlast,   // last_of_word
  output logic                              m_axis_tuser,   // all_done
  // Configuration writes.
  input  wire                               cfg_wr_en,
  input  wire  [psu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [psu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import psu_pkg::*;

  // Configuration and running counters.
  logic [SYM_BITS_W-1:0] symbol_bits;
  logic [TOTAL_W-1:0]    symbol_total;
  logic [TOTAL_W-1:0]    emitted_count;
  logic [TOTAL_W-1:0]    owed;          // symbol_total - emitted_count, kept as a register

  // Per-word working state.
  logic [WORD_BITS-1:0]  index_sr;      // next index to send sits in the top b bits
  logic [SYM_BITS_W-1:0] cur_bits;
  logic [COUNT_W-1:0]    left;          // symbols of this word still to send

  // Output register.
  logic [CODE_W-1:0]     out_code;
  logic [TOTAL_W-1:0]    out_number;
  logic                  out_last;
  logic                  out_done;

  logic                  in_xfer;
  logic                  advance;
  logic [COUNT_W-1:0]    word_slots;
  logic [COUNT_W-1:0]    word_k;
  logic [COUNT_W-1:0]    used_bits;
  logic [COUNT_W-1:0]    align_shift;
  logic [IDX_W-1:0]      top_bits;
  logic [IDX_W-1:0]      cur_index;
  logic [CODE_W-1:0]     cur_code;
  tbl_wr_t               tbl_wr;

  // A new word is taken only when the shifter is empty; the output register
  // keeps the last symbol of the previous word meanwhile.
  assign s_axis_tready = (left == '0);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign advance       = (left != '0) && (!m_axis_tvalid || m_axis_tready);

  // Count for the incoming word, then shift it left so that the highest of
  // its k indices lands in the top bits of the shift register.
  always_comb begin
    word_slots  = per_word(symbol_bits);
    word_k      = (owed < TOTAL_W'(word_slots)) ? owed[COUNT_W-1:0] : word_slots;
    used_bits   = COUNT_W'(word_k * symbol_bits);
    align_shift = COUNT_W'(WORD_BITS) - used_bits;
  end

  // Current index: the top cur_bits bits of the shift register.
  always_comb begin
    top_bits = index_sr[WORD_BITS-1 -: IDX_W];
    if (cur_bits == '0) begin
      cur_index = '0;
    end else begin
      cur_index = top_bits >> (SYM_BITS_W'(IDX_W) - cur_bits);
    end
  end

  // Table words go straight to the code table.
  always_comb begin
    tbl_wr.en   = 1'b0;
    tbl_wr.sel  = '0;
    tbl_wr.data = cfg_wdata;
    unique case (cfg_addr)
      CFG_TABLE_A: begin
        tbl_wr.en  = cfg_wr_en;
        tbl_wr.sel = 2'd0;
      end
      CFG_TABLE_B: begin
        tbl_wr.en  = cfg_wr_en;
        tbl_wr.sel = 2'd1;
      end
      CFG_TABLE_C: begin
        tbl_wr.en  = cfg_wr_en;
        tbl_wr.sel = 2'd2;
      end
      CFG_TABLE_D: begin
        tbl_wr.en  = cfg_wr_en;
        tbl_wr.sel = 2'd3;
      end
      default: begin
        tbl_wr.en = 1'b0;
      end
    endcase
  end

  psu_code_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_code_table (
    .clk      (clk),
    .rst      (rst),
    .tbl_wr   (tbl_wr),
    .rd_index (cur_index),
    .rd_code  (cur_code)
  );

  // Control state: counters, configuration and the word counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits   <= SYM_BITS_W'(1);
      symbol_total  <= '0;
      emitted_count <= '0;
      owed          <= '0;
      left          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (advance) begin
        emitted_count <= emitted_count + TOTAL_W'(1);
        owed          <= owed - TOTAL_W'(1);
        left          <= left - COUNT_W'(1);
      end else if (in_xfer && owed != '0) begin
        left <= word_k;
      end

      // Writes are to arrive only while the block is idle; the block does not enforce it.
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_SYMBOL_BITS: begin
            symbol_bits <= cfg_wdata[SYM_BITS_W-1:0];
          end
          CFG_SYMBOL_TOTAL: begin
            symbol_total  <= cfg_wdata[TOTAL_W-1:0];
            owed          <= cfg_wdata[TOTAL_W-1:0];
            emitted_count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload: shift register and output register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      index_sr <= s_axis_tdata << align_shift;
      cur_bits <= symbol_bits;
    end else if (advance) begin
      index_sr <= index_sr << cur_bits;
    end
    if (advance) begin
      out_code   <= cur_code;
      out_number <= emitted_count;
      out_last   <= (left == COUNT_W'(1));
      out_done   <= (owed == TOTAL_W'(1));
    end
  end

  assign m_axis_tdata = {out_number, out_code};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_done;

`ifndef ASSERT_OFF
  // The owed counter always mirrors the total less what has gone out.
  a_owed_tracks: assert property (@(posedge clk) disable iff (rst)
    emitted_count + owed == symbol_total)
    else $error("owed count out of step with emitted count");

  // The symbol that completes the total is always the last one of its word.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("all_done on a symbol that is not last of its word");

  // A word taken while symbols are owed starts the shifter.
  a_word_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer && owed != '0 && !cfg_wr_en |=> left != '0)
    else $error("accepted word produced no symbols");

  // The shifter never holds more symbols than a word can carry.
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    left <= COUNT_W'(WORD_BITS))
    else $error("symbol counter beyond word capacity");
`endif

endmodule

`default_nettype wire

// ----- design/psu_code_table.sv -----
// Symbol code table: TABLE_ENTRIES codes of eight bits, written a table word
// at a time, read at one index per cycle. Depends on psu_pkg.
`default_nettype none

module psu_code_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  psu_pkg::tbl_wr_t             tbl_wr,
  input  wire  [psu_pkg::IDX_W-1:0]    rd_index,
  output logic [psu_pkg::CODE_W-1:0]   rd_code
);
  import psu_pkg::*;

  localparam int ENT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [CODE_W-1:0] code_q [TABLE_ENTRIES];

  for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_entry
    localparam int WORD_SEL = e / CODES_PER_WORD;
    localparam int LANE     = e % CODES_PER_WORD;
    always_ff @(posedge clk) begin
      if (rst) begin
        code_q[e] <= '0;
      end else if (tbl_wr.en && tbl_wr.sel == TBL_SEL_W'(WORD_SEL)) begin
        code_q[e] <= tbl_wr.data[LANE*CODE_W +: CODE_W];
      end
    end
  end

  // Indices past the end of the table decode to code zero.
  always_comb begin
    if (32'(rd_index) < TABLE_ENTRIES) begin
      rd_code = code_q[rd_index[ENT_W-1:0]];
    end else begin
      rd_code = '0;
    end
  end

endmodule

`default_nettype wire
